// ===== src/tspa_pkg.sv =====
// shared constants and types for the transport stream packet aligner
package tspa_pkg;

  localparam int unsigned PktBytes   = 188;
  localparam int unsigned ChunkBytes = 1024;
  localparam int unsigned FifoBytes  = 2048;
  localparam int unsigned TailBytes  = PktBytes - 1;

  localparam int unsigned ChunkAw = $clog2(ChunkBytes);
  localparam int unsigned FifoAw  = $clog2(FifoBytes);
  localparam int unsigned TailAw  = $clog2(TailBytes);
  localparam int unsigned FillW   = $clog2(ChunkBytes + 1);
  localparam int unsigned LevelW  = $clog2(FifoBytes + 1);
  localparam int unsigned PhaseW  = $clog2(PktBytes);

  localparam logic [7:0] SyncReset = 8'd71;

  typedef enum logic [2:0] {
    ST_TAKEN     = 3'd0,
    ST_TAIL_USED = 3'd1,
    ST_TAIL_DROP = 3'd2,
    ST_NO_SYNC   = 3'd3,
    ST_BAD_CHUNK = 3'd4,
    ST_EMPTY     = 3'd5,
    ST_TOO_LONG  = 3'd6
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PULL,
    S_SPOT_RD,
    S_SPOT_CHK,
    S_SCAN_RD,
    S_SCAN_A,
    S_SCAN_B,
    S_TAIL_CP,
    S_HEAD_CP,
    S_PKT_CP,
    S_REM_CP,
    S_DONE
  } state_t;

endpackage

// ===== src/tspa_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
module tspa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/ts_packet_aligner_unit.sv =====
// top level of the transport stream packet aligner
// a push that does not end a chunk strobes in the cycle after its transfer; a pull reads the fifo,
//   then registers the byte in S_PULL; at a chunk end the block is busy for the tail spot check, the scan
//   of candidate offsets, then the copy of each byte and packet; results cannot be stalled
// throughput: one push per cycle while not busy; a pull holds busy until its byte is out
// reset: synchronous, active low; clears state, fill, level, phase and tail length; store contents undefined
module ts_packet_aligner_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_func,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_in_chunk,
  input  logic        in_chunk_ok,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  output logic        out_strobe,
  output logic [7:0]  out_out_byte,
  output logic        out_out_valid,
  output logic        out_packet_start,
  output logic [2:0]  out_status,
  output logic [10:0] out_emitted_count,
  output logic        out_overflow
);

  localparam int unsigned CAW = tspa_pkg::ChunkAw;
  localparam int unsigned FAW = tspa_pkg::FifoAw;
  localparam int unsigned TAW = tspa_pkg::TailAw;
  localparam int unsigned FW  = tspa_pkg::FillW;
  localparam int unsigned LW  = tspa_pkg::LevelW;
  localparam int unsigned PW  = tspa_pkg::PhaseW;
  localparam logic [FW-1:0] PKT  = FW'(tspa_pkg::PktBytes);
  localparam logic [LW-1:0] ROOM = LW'(tspa_pkg::FifoBytes - tspa_pkg::PktBytes);

  // control and counters
  tspa_pkg::state_t state_r, state_nxt;
  logic [7:0]    sync_r;
  logic [FW-1:0] fill_r, fill_nxt;
  logic          long_r, long_nxt;
  logic [FW-1:0] len_r, len_nxt;       // length of chunk being finished
  logic [FW-1:0] tlen_r, tlen_nxt;     // saved tail length
  logic [FAW-1:0] head_r, head_nxt;
  logic [LW-1:0] level_r, level_nxt;
  logic [PW-1:0] phase_r, phase_nxt;
  logic [FW-1:0] off_r, off_nxt;       // scan offset / copy source
  logic [FW-1:0] cnt_r, cnt_nxt;       // byte counter inside a copy
  logic [FW-1:0] st_r, st_nxt;         // found start
  logic [FW-1:0] pos_r, pos_nxt;       // packet copy position
  logic          drop_r, drop_nxt;     // current packet dropped (overflow, or a tail that does not join)
  logic          rdv_r, rdv_nxt;       // read data valid for copy pipeline
  logic          ovf_r, ovf_nxt;
  logic [10:0]   emit_r, emit_nxt;
  logic [2:0]    stat_r, stat_nxt;
  logic          pend_r, pend_nxt;     // copied byte waiting to be written

  // result registers
  logic        ostb_r, ostb_nxt;
  logic [7:0]  obyte_r, obyte_nxt;
  logic        oval_r, oval_nxt;
  logic        opst_r, opst_nxt;
  logic [2:0]  ost_r, ost_nxt;
  logic [10:0] oemit_r, oemit_nxt;
  logic        oovf_r, oovf_nxt;

  // memory ports
  logic           cwe, twe, fwe;
  logic [CAW-1:0] cwa, cra;
  logic [TAW-1:0] twa, tra;
  logic [FAW-1:0] fwa, fra;
  logic [7:0]     cwd, twd, fwd, crd, trd, frd;
  logic           src_tail_r, src_tail_nxt;  // copy source is tail store

  tspa_ram #(.Width(8), .Depth(tspa_pkg::ChunkBytes)) u_chunk (
    .clk(clk), .we(cwe), .waddr(cwa), .wdata(cwd), .raddr(cra), .rdata(crd));
  tspa_ram #(.Width(8), .Depth(tspa_pkg::TailBytes)) u_tail (
    .clk(clk), .we(twe), .waddr(twa), .wdata(twd), .raddr(tra), .rdata(trd));
  tspa_ram #(.Width(8), .Depth(tspa_pkg::FifoBytes)) u_fifo (
    .clk(clk), .we(fwe), .waddr(fwa), .wdata(fwd), .raddr(fra), .rdata(frd));

  logic [7:0] cp_byte;
  logic       accept;
  logic [FW-1:0] spot;
  logic [FAW-1:0] wptr;

  assign accept  = start && !busy;
  assign busy    = (state_r != tspa_pkg::S_IDLE);
  assign cp_byte = src_tail_r ? trd : crd;
  assign spot    = PKT - tlen_r;
  assign wptr    = head_r + FAW'(level_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tspa_pkg::S_IDLE;
      sync_r  <= tspa_pkg::SyncReset;
      fill_r  <= '0;
      long_r  <= 1'b0;
      tlen_r  <= '0;
      head_r  <= '0;
      level_r <= '0;
      phase_r <= '0;
      ostb_r  <= 1'b0;
      rdv_r   <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        sync_r <= cfg_wdata;
      end
      fill_r  <= fill_nxt;
      long_r  <= long_nxt;
      tlen_r  <= tlen_nxt;
      head_r  <= head_nxt;
      level_r <= level_nxt;
      phase_r <= phase_nxt;
      ostb_r  <= ostb_nxt;
      rdv_r   <= rdv_nxt;
      pend_r  <= pend_nxt;
    end
    len_r   <= len_nxt;
    off_r   <= off_nxt;
    cnt_r   <= cnt_nxt;
    st_r    <= st_nxt;
    pos_r   <= pos_nxt;
    drop_r  <= drop_nxt;
    ovf_r   <= ovf_nxt;
    emit_r  <= emit_nxt;
    stat_r  <= stat_nxt;
    src_tail_r <= src_tail_nxt;
    obyte_r <= obyte_nxt;
    oval_r  <= oval_nxt;
    opst_r  <= opst_nxt;
    ost_r   <= ost_nxt;
    oemit_r <= oemit_nxt;
    oovf_r  <= oovf_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    long_nxt  = long_r;
    len_nxt   = len_r;
    tlen_nxt  = tlen_r;
    head_nxt  = head_r;
    level_nxt = level_r;
    phase_nxt = phase_r;
    off_nxt   = off_r;
    cnt_nxt   = cnt_r;
    st_nxt    = st_r;
    pos_nxt   = pos_r;
    drop_nxt  = drop_r;
    ovf_nxt   = ovf_r;
    emit_nxt  = emit_r;
    stat_nxt  = stat_r;
    src_tail_nxt = src_tail_r;
    rdv_nxt   = 1'b0;
    pend_nxt  = 1'b0;
    ostb_nxt  = 1'b0;
    obyte_nxt = obyte_r;
    oval_nxt  = oval_r;
    opst_nxt  = opst_r;
    ost_nxt   = ost_r;
    oemit_nxt = oemit_r;
    oovf_nxt  = oovf_r;
    cwe = 1'b0; cwa = fill_r[CAW-1:0]; cwd = in_data_byte;
    twe = 1'b0; twa = cnt_r[TAW-1:0];  twd = crd;
    fwe = 1'b0; fwa = wptr;            fwd = cp_byte;
    cra = off_r[CAW-1:0];
    tra = off_r[TAW-1:0];
    fra = head_r;

    // a copied byte arrives in the cycle after its read; append it to the fifo
    if (pend_r) begin
      fwe = 1'b1;
      level_nxt = level_r + LW'(1);
    end

    case (state_r)
      tspa_pkg::S_IDLE: begin
        if (accept) begin
          obyte_nxt = '0; oval_nxt = 1'b0; opst_nxt = 1'b0;
          ost_nxt = tspa_pkg::ST_TAKEN; oemit_nxt = '0; oovf_nxt = 1'b0;
          if (in_func) begin
            if (level_r == '0) begin
              ost_nxt  = tspa_pkg::ST_EMPTY;
              ostb_nxt = 1'b1;
            end else begin
              state_nxt = tspa_pkg::S_PULL;
            end
          end else begin
            if (fill_r < FW'(tspa_pkg::ChunkBytes)) begin
              cwe = 1'b1;
              fill_nxt = fill_r + FW'(1);
            end else begin
              long_nxt = 1'b1;
              ost_nxt  = tspa_pkg::ST_TOO_LONG;
            end
            if (in_last_in_chunk) begin
              len_nxt  = (fill_r < FW'(tspa_pkg::ChunkBytes)) ? fill_r + FW'(1) : fill_r;
              fill_nxt = '0;
              long_nxt = 1'b0;
              emit_nxt = '0;
              ovf_nxt  = 1'b0;
              if (!in_chunk_ok) begin
                ost_nxt  = tspa_pkg::ST_BAD_CHUNK;
                ostb_nxt = 1'b1;
              end else if (long_r || fill_r >= FW'(tspa_pkg::ChunkBytes)) begin
                ost_nxt  = tspa_pkg::ST_TOO_LONG;
                ostb_nxt = 1'b1;
              end else begin
                state_nxt = tspa_pkg::S_SPOT_RD;
              end
            end else begin
              ostb_nxt = 1'b1;
            end
          end
        end
      end
      tspa_pkg::S_PULL: begin
        // fifo read issued at head last cycle
        obyte_nxt = frd;
        oval_nxt  = 1'b1;
        opst_nxt  = (phase_r == '0);
        ostb_nxt  = 1'b1;
        head_nxt  = head_r + FAW'(1);
        level_nxt = level_r - LW'(1);
        phase_nxt = (phase_r == PW'(tspa_pkg::PktBytes - 1)) ? '0 : phase_r + PW'(1);
        state_nxt = tspa_pkg::S_IDLE;
      end
      tspa_pkg::S_SPOT_RD: begin
        off_nxt = spot;
        cra = spot[CAW-1:0];
        if (spot < len_r) begin
          state_nxt = tspa_pkg::S_SPOT_CHK;
        end else begin
          off_nxt   = '0;
          state_nxt = tspa_pkg::S_SCAN_RD;
        end
      end
      tspa_pkg::S_SPOT_CHK: begin
        if (crd == sync_r) begin
          st_nxt    = off_r;
          state_nxt = tspa_pkg::S_TAIL_CP;
        end else begin
          off_nxt   = '0;
          state_nxt = tspa_pkg::S_SCAN_RD;
        end
      end
      tspa_pkg::S_SCAN_RD: begin
        // read candidate offset
        if (off_r + PKT > len_r) begin
          ost_nxt   = tspa_pkg::ST_NO_SYNC;
          ostb_nxt  = 1'b1;
          state_nxt = tspa_pkg::S_IDLE;
        end else begin
          state_nxt = tspa_pkg::S_SCAN_A;
        end
      end
      tspa_pkg::S_SCAN_A: begin
        cra = CAW'(off_r + PKT);
        if (crd != sync_r) begin
          off_nxt   = off_r + FW'(1);
          state_nxt = tspa_pkg::S_SCAN_RD;
        end else if (off_r + PKT == len_r) begin
          st_nxt    = off_r;
          state_nxt = tspa_pkg::S_TAIL_CP;
        end else begin
          state_nxt = tspa_pkg::S_SCAN_B;
        end
      end
      tspa_pkg::S_SCAN_B: begin
        if (crd == sync_r) begin
          st_nxt    = off_r;
          state_nxt = tspa_pkg::S_TAIL_CP;
        end else begin
          off_nxt   = off_r + FW'(1);
          state_nxt = tspa_pkg::S_SCAN_RD;
        end
      end
      tspa_pkg::S_TAIL_CP: begin
        // decide join; start tail copy from tail store
        pos_nxt = st_r;
        off_nxt = '0;
        cnt_nxt = '0;
        if (st_r + tlen_r == PKT) begin
          stat_nxt = tspa_pkg::ST_TAIL_USED;
          if (level_r <= ROOM) begin
            emit_nxt = 11'(tspa_pkg::PktBytes);
            drop_nxt = 1'b0;
          end else begin
            ovf_nxt  = 1'b1;
            drop_nxt = 1'b1;
          end
          src_tail_nxt = 1'b1;
          state_nxt = tspa_pkg::S_HEAD_CP;
        end else begin
          stat_nxt  = tspa_pkg::ST_TAIL_DROP;
          drop_nxt  = 1'b1;
          cnt_nxt   = PKT;
          state_nxt = tspa_pkg::S_HEAD_CP;
        end
      end
      tspa_pkg::S_HEAD_CP: begin
        // joined packet: tail bytes then chunk bytes up to start; cnt counts packet bytes
        if (cnt_r == PKT) begin
          tlen_nxt  = '0;
          off_nxt   = pos_r;
          cnt_nxt   = '0;
          state_nxt = tspa_pkg::S_PKT_CP;
        end else begin
          if (cnt_r < tlen_r) begin
            src_tail_nxt = 1'b1;
            tra = cnt_r[TAW-1:0];
          end else begin
            src_tail_nxt = 1'b0;
            cra = CAW'(cnt_r - tlen_r);
          end
          pend_nxt = !drop_r;
          cnt_nxt  = cnt_r + FW'(1);
        end
      end
      tspa_pkg::S_PKT_CP: begin
        src_tail_nxt = 1'b0;
        if (cnt_r == '0) begin
          if (pos_r + PKT > len_r) begin
            off_nxt   = pos_r;
            cnt_nxt   = '0;
            state_nxt = tspa_pkg::S_REM_CP;
          end else begin
            // room check against level after any pending write lands
            if (level_nxt <= ROOM) begin
              drop_nxt = 1'b0;
              emit_nxt = emit_r + 11'(tspa_pkg::PktBytes);
            end else begin
              drop_nxt = 1'b1;
              ovf_nxt  = 1'b1;
            end
            cnt_nxt = FW'(1);
            cra = pos_r[CAW-1:0];
            pend_nxt = (level_nxt <= ROOM);
          end
        end else if (cnt_r == PKT) begin
          pos_nxt = pos_r + PKT;
          cnt_nxt = '0;
        end else begin
          cra = CAW'(pos_r + cnt_r);
          pend_nxt = !drop_r;
          cnt_nxt  = cnt_r + FW'(1);
        end
      end
      tspa_pkg::S_REM_CP: begin
        // leftover bytes become the new tail; each is read, then written in the cycle after
        cra = CAW'(pos_r + cnt_r);
        if (rdv_r) begin
          twe = 1'b1;
          twa = TAW'(cnt_r - FW'(1));
        end
        if (pos_r + cnt_r < len_r) begin
          rdv_nxt = 1'b1;
          cnt_nxt = cnt_r + FW'(1);
        end else begin
          tlen_nxt  = len_r - pos_r;
          state_nxt = tspa_pkg::S_DONE;
        end
      end
      tspa_pkg::S_DONE: begin
        ost_nxt   = stat_r;
        oemit_nxt = emit_r;
        oovf_nxt  = ovf_r;
        ostb_nxt  = 1'b1;
        state_nxt = tspa_pkg::S_IDLE;
      end
      default: begin
        state_nxt = tspa_pkg::S_IDLE;
      end
    endcase
  end

  assign out_strobe        = ostb_r;
  assign out_out_byte      = obyte_r;
  assign out_out_valid     = oval_r;
  assign out_packet_start  = opst_r;
  assign out_status        = ost_r;
  assign out_emitted_count = oemit_r;
  assign out_overflow      = oovf_r;

  // the fifo never holds more than its depth
  assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= LW'(tspa_pkg::FifoBytes))
    else $error("fifo level beyond depth");

  // the tail is always shorter than one packet
  assert property (@(posedge clk) disable iff (!rst_n)
    tlen_r < PKT)
    else $error("tail length too large");

  // an accepted item always makes busy or a strobe next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (busy || out_strobe))
    else $error("accepted item lost");

  // a strobe with valid byte follows only a pull
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_out_valid) |-> $past(state_r == tspa_pkg::S_PULL))
    else $error("valid byte without pull");

endmodule

// ===== tb/tb_ts_packet_aligner_unit.sv =====
// testbench for the transport stream packet aligner: directed table, then random chunk traffic
`timescale 1ns / 1ps

module tb_ts_packet_aligner_unit;

  // one input transfer
  typedef struct {
    logic       func;
    logic [7:0] data;
    logic       last;
    logic       ok;
  } item_t;

  // one result transfer
  typedef struct {
    logic [7:0]        byte_v;
    logic              valid;
    logic              pstart;
    tspa_pkg::status_t status;
    logic [10:0]       emitted;
    logic              ovf;
  } res_t;

  // directed row: stimulus plus an optional typed-in expectation
  typedef struct {
    item_t item;
    bit    fixed;
    res_t  res;
  } row_t;

  localparam int unsigned LimitCycles = 3000000;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_func;
  logic [7:0]  in_data_byte;
  logic        in_last_in_chunk;
  logic        in_chunk_ok;
  logic        cfg_we;
  logic [7:0]  cfg_wdata;
  logic        out_strobe;
  logic [7:0]  out_out_byte;
  logic        out_out_valid;
  logic        out_packet_start;
  logic [2:0]  out_status;
  logic [10:0] out_emitted_count;
  logic        out_overflow;

  ts_packet_aligner_unit i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_func           (in_func),
    .in_data_byte      (in_data_byte),
    .in_last_in_chunk  (in_last_in_chunk),
    .in_chunk_ok       (in_chunk_ok),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .out_strobe        (out_strobe),
    .out_out_byte      (out_out_byte),
    .out_out_valid     (out_out_valid),
    .out_packet_start  (out_packet_start),
    .out_status        (out_status),
    .out_emitted_count (out_emitted_count),
    .out_overflow      (out_overflow)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // aligner mirror state
  logic [7:0]  m_sync;
  logic [7:0]  m_chunk [tspa_pkg::ChunkBytes];
  int unsigned m_fill;
  bit          m_long;
  logic [7:0]  m_tail [tspa_pkg::PktBytes];
  int unsigned m_tail_len;
  logic [7:0]  m_fifo [tspa_pkg::FifoBytes];
  int unsigned m_head;
  int unsigned m_level;
  int unsigned m_phase;

  res_t        pending_q[$];
  int unsigned fail_cnt;
  int unsigned cycle_cnt;

  function automatic void mirror_reset();
    m_sync     = tspa_pkg::SyncReset;
    m_fill     = 0;
    m_long     = 0;
    m_tail_len = 0;
    m_head     = 0;
    m_level    = 0;
    m_phase    = 0;
  endfunction

  function automatic void fifo_push(logic [7:0] b);
    m_fifo[(m_head + m_level) % tspa_pkg::FifoBytes] = b;
    m_level++;
  endfunction

  function automatic bit fifo_fits();
    return m_level + tspa_pkg::PktBytes <= tspa_pkg::FifoBytes;
  endfunction

  // spot that completes the tail first, then a confirmed sync byte
  function automatic bit locate_start(int unsigned len, output int unsigned st);
    int unsigned spot;
    spot = tspa_pkg::PktBytes - m_tail_len;
    st = 0;
    if (spot < len && m_chunk[spot] == m_sync) begin
      st = spot;
      return 1;
    end
    if (len < tspa_pkg::PktBytes) return 0;
    for (int unsigned off = 0; off + tspa_pkg::PktBytes <= len; off++) begin
      if (m_chunk[off] != m_sync) continue;
      if (off + tspa_pkg::PktBytes == len || m_chunk[off + tspa_pkg::PktBytes] == m_sync) begin
        st = off;
        return 1;
      end
    end
    return 0;
  endfunction

  function automatic void close_chunk(bit ok, inout res_t r);
    int unsigned len, st, pos, cnt, emitted;
    bit          was_long, ovf;
    len      = m_fill;
    was_long = m_long;
    emitted  = 0;
    ovf      = 0;
    m_fill   = 0;
    m_long   = 0;
    if (!ok) begin
      r.status = tspa_pkg::ST_BAD_CHUNK;
      return;
    end
    if (was_long) begin
      r.status = tspa_pkg::ST_TOO_LONG;
      return;
    end
    if (!locate_start(len, st)) begin
      r.status = tspa_pkg::ST_NO_SYNC;
      return;
    end
    if (st + m_tail_len == tspa_pkg::PktBytes) begin
      if (fifo_fits()) begin
        for (int unsigned k = 0; k < m_tail_len; k++) fifo_push(m_tail[k]);
        for (int unsigned k = 0; k < st; k++) fifo_push(m_chunk[k]);
        emitted += tspa_pkg::PktBytes;
      end else begin
        ovf = 1;
      end
      r.status = tspa_pkg::ST_TAIL_USED;
    end else begin
      r.status = tspa_pkg::ST_TAIL_DROP;
    end
    m_tail_len = 0;
    cnt = (len - st) / tspa_pkg::PktBytes;
    pos = st;
    for (int unsigned k = 0; k < cnt; k++) begin
      if (fifo_fits()) begin
        for (int unsigned j = 0; j < tspa_pkg::PktBytes; j++) fifo_push(m_chunk[pos + j]);
        emitted += tspa_pkg::PktBytes;
      end else begin
        ovf = 1;
      end
      pos += tspa_pkg::PktBytes;
    end
    for (int unsigned k = 0; k < len - pos; k++) m_tail[k] = m_chunk[pos + k];
    m_tail_len = len - pos;
    r.emitted = emitted[10:0];
    r.ovf     = ovf;
  endfunction

  function automatic res_t predict_aligned(item_t it);
    res_t r;
    r = '{8'd0, 1'b0, 1'b0, tspa_pkg::ST_TAKEN, 11'd0, 1'b0};
    if (it.func) begin
      if (m_level == 0) begin
        r.status = tspa_pkg::ST_EMPTY;
        return r;
      end
      r.byte_v = m_fifo[m_head];
      r.valid  = 1'b1;
      r.pstart = (m_phase == 0);
      m_head   = (m_head + 1) % tspa_pkg::FifoBytes;
      m_level--;
      m_phase  = (m_phase + 1) % tspa_pkg::PktBytes;
      return r;
    end
    if (m_fill < tspa_pkg::ChunkBytes) begin
      m_chunk[m_fill] = it.data;
      m_fill++;
    end else begin
      m_long   = 1;
      r.status = tspa_pkg::ST_TOO_LONG;
    end
    if (it.last) close_chunk(it.ok, r);
    return r;
  endfunction

  // result checking: the receiver cannot stall, so every strobe is compared at once
  always @(posedge clk) begin
    res_t e;
    if (rst_n && out_strobe) begin
      if (pending_q.size() == 0) begin
        $error("result with no expectation waiting");
        fail_cnt++;
      end else begin
        e = pending_q.pop_front();
        if (out_out_byte !== e.byte_v) begin
          $error("out_byte exp %0d got %0d", e.byte_v, out_out_byte);
          fail_cnt++;
        end
        if (out_out_valid !== e.valid) begin
          $error("out_valid exp %0d got %0d", e.valid, out_out_valid);
          fail_cnt++;
        end
        if (out_packet_start !== e.pstart) begin
          $error("packet_start exp %0d got %0d", e.pstart, out_packet_start);
          fail_cnt++;
        end
        if (out_status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_status);
          fail_cnt++;
        end
        if (out_emitted_count !== e.emitted) begin
          $error("emitted_count exp %0d got %0d", e.emitted, out_emitted_count);
          fail_cnt++;
        end
        if (out_overflow !== e.ovf) begin
          $error("overflow exp %0d got %0d", e.ovf, out_overflow);
          fail_cnt++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LimitCycles) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // random gap, mostly short with the odd long one; start drops only for a real gap
  task automatic idle_gap();
    int unsigned n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    if (n != 0) start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // one input transfer: hold start until the block takes it; the caller releases start
  task automatic send_item(item_t it, bit fixed, res_t fx);
    res_t p;
    start            <= 1'b1;
    in_func          <= it.func;
    in_data_byte     <= it.data;
    in_last_in_chunk <= it.last;
    in_chunk_ok      <= it.ok;
    p = predict_aligned(it);
    if (fixed) p = fx;
    pending_q.push_back(p);
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic push_byte(logic [7:0] b, bit last, bit ok);
    item_t it;
    res_t  z;
    it = '{1'b0, b, last, ok};
    z  = '{8'd0, 1'b0, 1'b0, tspa_pkg::ST_TAKEN, 11'd0, 1'b0};
    send_item(it, 0, z);
    idle_gap();
  endtask

  task automatic pull_byte();
    item_t it;
    res_t  z;
    it = '{1'b1, 8'($urandom), 1'($urandom), 1'($urandom)};
    z  = '{8'd0, 1'b0, 1'b0, tspa_pkg::ST_TAKEN, 11'd0, 1'b0};
    send_item(it, 0, z);
    idle_gap();
  endtask

  // wait until every result is in, plus the sequencer's tail
  task automatic drain();
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_sync(logic [7:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    m_sync = v;
  endtask

  // chunk of well-formed packets at a random phase, optional corruption
  task automatic send_chunk(int unsigned len, int unsigned phase, bit noisy);
    logic [7:0] b;
    bit         ok;
    ok = ($urandom_range(0, 19) != 0);
    for (int unsigned i = 0; i < len; i++) begin
      b = ((i + phase) % tspa_pkg::PktBytes == 0) ? m_sync : 8'($urandom);
      if (noisy && $urandom_range(0, 60) == 0) b = 8'($urandom);
      push_byte(b, i == len - 1, ok);
    end
  endtask

  row_t        dir_tab[$];
  int unsigned stream_pos;
  int unsigned n_items;

  function automatic row_t mk(logic f, logic [7:0] d, logic l, logic o,
                              bit fx, tspa_pkg::status_t s);
    row_t r;
    r.item  = '{f, d, l, o};
    r.fixed = fx;
    r.res   = '{8'd0, 1'b0, 1'b0, s, 11'd0, 1'b0};
    return r;
  endfunction

  initial begin
    res_t r0;
    start            <= 1'b0;
    in_func          <= 1'b0;
    in_data_byte     <= 8'd0;
    in_last_in_chunk <= 1'b0;
    in_chunk_ok      <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_wdata        <= 8'd0;
    rst_n            <= 1'b0;
    fail_cnt  = 0;
    cycle_cnt = 0;
    mirror_reset();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows: pull from empty, one-byte chunks, bad chunk, extremes of data
    dir_tab.push_back(mk(1'b1, 8'hff, 1'b1, 1'b1, 1, tspa_pkg::ST_EMPTY));
    dir_tab.push_back(mk(1'b1, 8'h00, 1'b0, 1'b0, 1, tspa_pkg::ST_EMPTY));
    dir_tab.push_back(mk(1'b0, 8'h47, 1'b0, 1'b1, 1, tspa_pkg::ST_TAKEN));
    dir_tab.push_back(mk(1'b0, 8'hff, 1'b1, 1'b0, 1, tspa_pkg::ST_BAD_CHUNK));
    dir_tab.push_back(mk(1'b0, 8'h00, 1'b1, 1'b1, 1, tspa_pkg::ST_NO_SYNC));
    dir_tab.push_back(mk(1'b0, 8'h47, 1'b1, 1'b1, 1, tspa_pkg::ST_NO_SYNC));
    foreach (dir_tab[i]) begin
      r0 = dir_tab[i].res;
      if (!dir_tab[i].fixed) r0 = '{8'd0, 1'b0, 1'b0, tspa_pkg::ST_TAKEN, 11'd0, 1'b0};
      send_item(dir_tab[i].item, dir_tab[i].fixed, r0);
      idle_gap();
    end
    // exact packet chunk, then tail split across chunks, then pulls
    send_chunk(tspa_pkg::PktBytes, 0, 0);
    send_chunk(100, 0, 0);
    send_chunk(tspa_pkg::PktBytes + 40, 100, 0);
    repeat (8) pull_byte();

    // chunk too long, one byte beyond the store before the last
    for (int unsigned i = 0; i < tspa_pkg::ChunkBytes + 1; i++) push_byte(8'($urandom), 0, 1);
    push_byte(8'h47, 1, 1);

    // random part across several sync values, extremes among them
    n_items = 0;
    stream_pos = 0;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_sync(8'h00);
        1: write_sync(8'hff);
        2: write_sync(8'($urandom));
        default: write_sync(tspa_pkg::SyncReset);
      endcase
      while (n_items < 60 * (ph + 1)) begin
        int unsigned len;
        case ($urandom_range(0, 9))
          0: begin
            // short noise chunk
            len = $urandom_range(1, 20);
            for (int unsigned i = 0; i < len; i++)
              push_byte(8'($urandom), i == len - 1, 1'($urandom));
          end
          1, 2, 3: begin
            repeat ($urandom_range(1, 60)) pull_byte();
            len = 0;
          end
          default: begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(300, 800)
                                               : $urandom_range(20, 260);
            send_chunk(len, stream_pos % tspa_pkg::PktBytes, 1);
            stream_pos += len;
          end
        endcase
        n_items += (len == 0) ? 30 : len;
        if ($urandom_range(0, 40) == 0) drain();
      end
    end
    // empty the fifo so reads cover wrap and empty again
    drain();
    while (m_level != 0) pull_byte();
    pull_byte();

    drain();
    repeat (50) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/tspa_pkg.sv
src/tspa_ram.sv
src/ts_packet_aligner_unit.sv
tb/tb_ts_packet_aligner_unit.sv
